// ===== src/abt_pkg.sv =====
package abt_pkg;

  localparam int MAX_DIM_DEF = 1024;
  localparam int IDX_W       = 20;
  localparam int VEL_W       = 16;
  localparam int TS_W        = 16;
  localparam int CFG_W       = 11;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int COORD_W     = 10;
  localparam int FRAC_W      = 16;
  localparam int WGT_W       = 17;
  localparam int ND_W        = VEL_W + TS_W + 1;
  localparam int SHIFT_W     = ND_W - 20;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 112;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 2'd2;

  localparam logic [CFG_W-1:0] RST_GRID_DIM  = 11'd64;
  localparam logic [TS_W-1:0]  RST_TIME_STEP = 16'd4096;

  // item handed from the front to the back: index and negated displacements (Q.20)
  typedef struct packed {
    logic [IDX_W-1:0]       idx;
    logic signed [ND_W-1:0] nd_x;
    logic signed [ND_W-1:0] nd_y;
  } abt_item_t;

  function automatic int clamp_dim(input logic [CFG_W-1:0] d, input int maxd);
    int v;
    v = int'(d);
    if (v < 2) begin
      return 2;
    end
    if (v > maxd) begin
      return maxd;
    end
    return v;
  endfunction

endpackage

// ===== src/abt_front.sv =====
module abt_front
  import abt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [IDX_W-1:0]      in_idx,
  input  logic signed [VEL_W-1:0] in_vel_x,
  input  logic signed [VEL_W-1:0] in_vel_y,
  input  logic [TS_W-1:0]       time_step,
  output logic                  push_valid,
  input  logic                  push_ready,
  output abt_item_t             push_item
);

  logic      vld;
  abt_item_t item;
  logic signed [ND_W-1:0] prod_x;
  logic signed [ND_W-1:0] prod_y;

  assign in_ready   = !vld || push_ready;
  assign push_valid = vld;
  assign push_item  = item;

  assign prod_x = ND_W'(in_vel_x * $signed({1'b0, time_step}));
  assign prod_y = ND_W'(in_vel_y * $signed({1'b0, time_step}));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.idx  <= in_idx;
      item.nd_x <= -prod_x;
      item.nd_y <= -prod_y;
    end
  end

endmodule

// ===== src/abt_queue.sv =====
module abt_queue
  import abt_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  abt_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output abt_item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  abt_item_t       mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count != (PW+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> !do_pop)
    else $error("pop from empty queue");

endmodule

// ===== src/abt_back.sv =====
module abt_back
  import abt_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [$clog2(MAX_DIM+1)-1:0] dim_w,
  input  logic [$clog2(MAX_DIM+1)-1:0] dim_h,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  abt_item_t            pop_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   base_x,
  output logic [COORD_W-1:0]   base_y,
  output logic [COORD_W-1:0]   next_x,
  output logic [COORD_W-1:0]   next_y,
  output logic [WGT_W-1:0]     weight_00,
  output logic [WGT_W-1:0]     weight_10,
  output logic [WGT_W-1:0]     weight_01,
  output logic [WGT_W-1:0]     weight_11
);

  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int QW   = ((DW + 12) > 21) ? (DW + 12) : 21;
  localparam int DIVN = IDX_W;
  localparam int MODN = QW;

  logic en;
  assign en        = !out_valid || out_ready;
  assign pop_ready = en;

  // divider: row = idx / w, col = idx % w, one quotient bit per stage
  logic                   d_vld [DIVN+1];
  logic [IDX_W-1:0]       d_idx [DIVN+1];
  logic [DW-1:0]          d_rem [DIVN+1];
  logic signed [ND_W-1:0] d_ndx [DIVN+1];
  logic signed [ND_W-1:0] d_ndy [DIVN+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld[0] <= 1'b0;
    end else if (en) begin
      d_vld[0] <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_idx[0] <= pop_item.idx;
      d_rem[0] <= '0;
      d_ndx[0] <= pop_item.nd_x;
      d_ndy[0] <= pop_item.nd_y;
    end
  end

  for (genvar i = 0; i < DIVN; i++) begin : g_div
    logic [DW:0] t;
    logic        ge;
    assign t  = {d_rem[i], d_idx[i][IDX_W-1]};
    assign ge = t >= {1'b0, dim_w};

    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld[i+1] <= 1'b0;
      end else if (en) begin
        d_vld[i+1] <= d_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_idx[i+1] <= {d_idx[i][IDX_W-2:0], ge};
        d_rem[i+1] <= ge ? DW'(t - {1'b0, dim_w}) : DW'(t);
        d_ndx[i+1] <= d_ndx[i];
        d_ndy[i+1] <= d_ndy[i];
      end
    end
  end

  // shifted coordinate made non-negative by adding dim * 2048
  logic signed [QW:0] ax;
  logic signed [QW:0] ay;
  logic signed [SHIFT_W-1:0] sx;
  logic signed [SHIFT_W-1:0] sy;
  assign sx = d_ndx[DIVN][ND_W-1:20];
  assign sy = d_ndy[DIVN][ND_W-1:20];
  assign ax = $signed({{(QW+1-DW){1'b0}}, d_rem[DIVN]})
            + $signed({{(QW+1-SHIFT_W){sx[SHIFT_W-1]}}, sx})
            + $signed({{(QW-10-DW){1'b0}}, dim_w, 11'b0});
  assign ay = $signed({{(QW+1-IDX_W){1'b0}}, d_idx[DIVN]})
            + $signed({{(QW+1-SHIFT_W){sy[SHIFT_W-1]}}, sy})
            + $signed({{(QW-10-DW){1'b0}}, dim_h, 11'b0});

  // periodic wrap: remainder by dim, one bit per stage, both axes side by side
  logic              m_vld [MODN+1];
  logic [QW-1:0]     m_vx  [MODN+1];
  logic [QW-1:0]     m_vy  [MODN+1];
  logic [DW-1:0]     m_rx  [MODN+1];
  logic [DW-1:0]     m_ry  [MODN+1];
  logic [FRAC_W-1:0] m_fx  [MODN+1];
  logic [FRAC_W-1:0] m_fy  [MODN+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld[0] <= 1'b0;
    end else if (en) begin
      m_vld[0] <= d_vld[DIVN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_vx[0] <= ax[QW-1:0];
      m_vy[0] <= ay[QW-1:0];
      m_rx[0] <= '0;
      m_ry[0] <= '0;
      m_fx[0] <= d_ndx[DIVN][19:4];
      m_fy[0] <= d_ndy[DIVN][19:4];
    end
  end

  for (genvar i = 0; i < MODN; i++) begin : g_mod
    logic [DW:0] tx;
    logic [DW:0] ty;
    logic        gx;
    logic        gy;
    assign tx = {m_rx[i], m_vx[i][QW-1]};
    assign ty = {m_ry[i], m_vy[i][QW-1]};
    assign gx = tx >= {1'b0, dim_w};
    assign gy = ty >= {1'b0, dim_h};

    always_ff @(posedge clk) begin
      if (rst) begin
        m_vld[i+1] <= 1'b0;
      end else if (en) begin
        m_vld[i+1] <= m_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_vx[i+1] <= {m_vx[i][QW-2:0], 1'b0};
        m_vy[i+1] <= {m_vy[i][QW-2:0], 1'b0};
        m_rx[i+1] <= gx ? DW'(tx - {1'b0, dim_w}) : DW'(tx);
        m_ry[i+1] <= gy ? DW'(ty - {1'b0, dim_h}) : DW'(ty);
        m_fx[i+1] <= m_fx[i];
        m_fy[i+1] <= m_fy[i];
      end
    end
  end

  // neighbours and fx * fy
  logic              p_vld;
  logic [DW-1:0]     p_bx;
  logic [DW-1:0]     p_by;
  logic [DW-1:0]     p_nx;
  logic [DW-1:0]     p_ny;
  logic [FRAC_W-1:0] p_fx;
  logic [FRAC_W-1:0] p_fy;
  logic [2*FRAC_W-1:0] p_prod;
  logic [DW:0]       inc_x;
  logic [DW:0]       inc_y;

  assign inc_x = {1'b0, m_rx[MODN]} + 1'b1;
  assign inc_y = {1'b0, m_ry[MODN]} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= m_vld[MODN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_bx   <= m_rx[MODN];
      p_by   <= m_ry[MODN];
      p_nx   <= (inc_x >= {1'b0, dim_w}) ? '0 : inc_x[DW-1:0];
      p_ny   <= (inc_y >= {1'b0, dim_h}) ? '0 : inc_y[DW-1:0];
      p_fx   <= m_fx[MODN];
      p_fy   <= m_fy[MODN];
      p_prod <= m_fx[MODN] * m_fy[MODN];
    end
  end

  logic [WGT_W-1:0] w11;
  assign w11 = {1'b0, p_prod[2*FRAC_W-1:FRAC_W]};

  logic [DW-1:0] o_bx;
  logic [DW-1:0] o_nx;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_bx      <= p_bx;
      o_nx      <= p_nx;
      base_x    <= COORD_W'(p_bx);
      base_y    <= COORD_W'(p_by);
      next_x    <= COORD_W'(p_nx);
      next_y    <= COORD_W'(p_ny);
      weight_11 <= w11;
      weight_10 <= {1'b0, p_fx} - w11;
      weight_01 <= {1'b0, p_fy} - w11;
      weight_00 <= 17'h10000 - {1'b0, p_fx} - {1'b0, p_fy} + w11;
    end
  end

  logic [WGT_W+1:0] wsum;
  assign wsum = {2'b0, weight_00} + {2'b0, weight_10} + {2'b0, weight_01}
              + {2'b0, weight_11};

  a_wsum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> wsum == 19'h10000)
    else $error("weights do not sum to one");

  a_base_in_grid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> o_bx < dim_w)
    else $error("base column outside grid");

  a_next_x: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (o_nx == '0 || {1'b0, o_nx} == {1'b0, o_bx} + 1'b1))
    else $error("right neighbour inconsistent with base");

endmodule

// ===== src/advection_backtrace_bilinear_core.sv =====
// Semi-Lagrangian back-trace with bilinear weights on a periodic grid.
// Input stream s_axis: one request per cell (linear index, velocity x/y).
// Output stream m_axis: one result per request, in order: base cell,
// right/upper neighbours (wrapping to zero) and four Q1.16 weights.
// Configuration: cfg_we/cfg_index/cfg_data write grid width, grid height
// and time step; write only while no request is in flight.
// Throughput: one request per cycle, sustained while m_axis_tready stays high.
// Path from acceptance to result: front register, queue, divider input,
// bit-per-stage index divider (20 stages), wrap input, bit-per-stage wrap
// remainder (QW stages, QW being 23 at MAX_DIM = 1024), neighbours, output.
// A front register and a four-entry queue part intake from the pipeline;
// when the receiver stalls the pipeline freezes, the queue fills and
// s_axis_tready then falls. Nothing is dropped.
// Reset (rst, synchronous) empties pipeline and queue and restores
// width 64, height 64, time step 4096 (one).
module advection_backtrace_bilinear_core
  import abt_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // cell_index[19:0], vel_x[35:20], vel_y[51:36], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // base_x[9:0], base_y[19:10], next_x[29:20], next_y[39:30], weight_00[56:40],
  // weight_10[73:57], weight_01[90:74], weight_11[107:91], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DW = $clog2(MAX_DIM + 1);

  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;
  logic [TS_W-1:0]  time_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= RST_GRID_DIM;
      grid_height <= RST_GRID_DIM;
      time_step   <= RST_TIME_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data[CFG_W-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[CFG_W-1:0];
        REG_TIME_STEP:   time_step   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DW-1:0] dim_w;
  logic [DW-1:0] dim_h;
  assign dim_w = DW'(clamp_dim(grid_width, MAX_DIM));
  assign dim_h = DW'(clamp_dim(grid_height, MAX_DIM));

  logic      push_valid;
  logic      push_ready;
  abt_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  abt_item_t pop_item;

  abt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_idx     (s_axis_tdata[19:0]),
    .in_vel_x   ($signed(s_axis_tdata[35:20])),
    .in_vel_y   ($signed(s_axis_tdata[51:36])),
    .time_step  (time_step),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  abt_queue #(.DEPTH(4)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  logic [COORD_W-1:0] base_x;
  logic [COORD_W-1:0] base_y;
  logic [COORD_W-1:0] next_x;
  logic [COORD_W-1:0] next_y;
  logic [WGT_W-1:0]   weight_00;
  logic [WGT_W-1:0]   weight_10;
  logic [WGT_W-1:0]   weight_01;
  logic [WGT_W-1:0]   weight_11;

  abt_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk       (clk),
    .rst       (rst),
    .dim_w     (dim_w),
    .dim_h     (dim_h),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .base_x    (base_x),
    .base_y    (base_y),
    .next_x    (next_x),
    .next_y    (next_y),
    .weight_00 (weight_00),
    .weight_10 (weight_10),
    .weight_01 (weight_01),
    .weight_11 (weight_11)
  );

  assign m_axis_tdata = {4'b0, weight_11, weight_01, weight_10, weight_00,
                         next_y, next_x, base_y, base_x};

endmodule

// ===== sim/tb.sv =====
module tb;
  import abt_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [VEL_W-1:0] vx;
    logic [VEL_W-1:0] vy;
  } cell_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] bx, by, nx, ny;
    logic [WGT_W-1:0]   w00, w10, w01, w11;
  } trace_res_t;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_GRID_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  advection_backtrace_bilinear_core uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cell_req_t  pending_q[$];
  trace_res_t traced_q[$];
  int unsigned grid_w = 64, grid_h = 64, tstep = 4096;
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;       // no idling on either side
  int hold_off = 0;      // receiver stall length, counted down below

  // one axis of the back-trace, all in Q.20
  task automatic trace_axis(input longint coord, input logic [VEL_W-1:0] vel,
                            input longint dim, output int unsigned base,
                            output int unsigned nxt, output int unsigned frac);
    longint p, m, r;
    p = (coord <<< 20) - longint'($signed(vel)) * longint'(tstep);
    m = dim <<< 20;
    r = p % m;
    if (r < 0) r += m;
    base = int'(r >>> 20);
    nxt = (base + 1 >= dim) ? 0 : base + 1;
    frac = int'((r & 64'hFFFFF) >>> 4);
  endtask

  function automatic int unsigned dim_used(int unsigned d);
    return d < 2 ? 2 : (d > 1024 ? 1024 : d);
  endfunction

  task automatic predict_trace(input cell_req_t c);
    trace_res_t t;
    int unsigned w, h, bx, by, nx, ny, fx, fy, w11;
    w = dim_used(grid_w);
    h = dim_used(grid_h);
    trace_axis(longint'(c.idx % w), c.vx, longint'(w), bx, nx, fx);
    trace_axis(longint'(c.idx / w), c.vy, longint'(h), by, ny, fy);
    w11 = int'((longint'(fx) * longint'(fy)) >>> 16);
    t.bx = COORD_W'(bx); t.by = COORD_W'(by);
    t.nx = COORD_W'(nx); t.ny = COORD_W'(ny);
    t.w11 = WGT_W'(w11);
    t.w10 = WGT_W'(fx - w11);
    t.w01 = WGT_W'(fy - w11);
    t.w00 = WGT_W'(65536 - fx - fy + w11);
    traced_q.push_back(t);
  endtask

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) predict_trace(pending_q.pop_front());
      if ((!s_axis_tvalid || s_axis_tready) ) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'b0, pending_q[0].vy, pending_q[0].vx, pending_q[0].idx};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall countdown
  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // monitor
  always @(posedge clk) begin
    trace_res_t got, exp_t;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.bx = m_axis_tdata[9:0];     got.by = m_axis_tdata[19:10];
        got.nx = m_axis_tdata[29:20];   got.ny = m_axis_tdata[39:30];
        got.w00 = m_axis_tdata[56:40];  got.w10 = m_axis_tdata[73:57];
        got.w01 = m_axis_tdata[90:74];  got.w11 = m_axis_tdata[107:91];
        if (traced_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          errors <= errors + 1;
        end else begin
          exp_t = traced_q.pop_front();
          if (got != exp_t) begin
            $display("%0t: mismatch exp bx%0d by%0d nx%0d ny%0d w %0d %0d %0d %0d",
                     $time, exp_t.bx, exp_t.by, exp_t.nx, exp_t.ny,
                     exp_t.w00, exp_t.w10, exp_t.w01, exp_t.w11);
            $display("%0t:          got bx%0d by%0d nx%0d ny%0d w %0d %0d %0d %0d",
                     $time, got.bx, got.by, got.nx, got.ny,
                     got.w00, got.w10, got.w01, got.w11);
            errors <= errors + 1;
          end
        end
      end
      if (hold_off > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || $urandom_range(99) >= 22;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic cell_req_t rand_req();
    cell_req_t c;
    int unsigned w, h;
    w = dim_used(grid_w);
    h = dim_used(grid_h);
    case ($urandom_range(9))
      0: c.idx = IDX_W'($urandom());                 // any index, rows beyond grid
      1: c.idx = IDX_W'(w * h - 1 - $urandom_range(w));  // near the top edge
      default: c.idx = IDX_W'($urandom_range(w * h - 1));
    endcase
    case ($urandom_range(5))
      0: c.vx = VEL_W'($urandom());
      1: c.vx = VEL_W'(16'h8000 | $urandom_range(3));
      default: c.vx = VEL_W'($urandom_range(4095) - 2048);
    endcase
    case ($urandom_range(5))
      0: c.vy = VEL_W'($urandom());
      1: c.vy = VEL_W'(16'h7FFF - $urandom_range(3));
      default: c.vy = VEL_W'($urandom_range(4095) - 2048);
    endcase
    return c;
  endfunction

  task automatic push_req(input logic [IDX_W-1:0] i, input logic [VEL_W-1:0] x,
                          input logic [VEL_W-1:0] y);
    cell_req_t c;
    c.idx = i; c.vx = x; c.vy = y;
    pending_q.push_back(c);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid || traced_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      REG_GRID_WIDTH:  grid_w = 32'(v & 16'h7FF);
      REG_GRID_HEIGHT: grid_h = 32'(v & 16'h7FF);
      REG_TIME_STEP:   tstep = 32'(v);
      default: ;
    endcase
  endtask

  initial begin
    int unsigned ws[6] = '{2, 1024, 0, 2047, 7, 33};
    int unsigned hs[6] = '{2, 1024, 1, 1500, 64, 19};
    int unsigned ts[6] = '{0, 65535, 4096, 1, 20000, 777};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, reset configuration
    push_req(20'd0, 16'h0000, 16'h0000);
    push_req(20'hFFFFF, 16'hFFFF, 16'hFFFF);
    push_req(20'd0, 16'h0100, 16'h0100);        // exact step back to -1 cell
    push_req(20'd0, 16'h4000, 16'hC000);        // exact multiple of the dimension
    push_req(20'd63, 16'hFF00, 16'h0000);       // last column stepping right
    push_req(20'd4095, 16'h7FFF, 16'h8000);
    push_req(20'd4095, 16'h8000, 16'h7FFF);
    push_req(20'h55555, 16'h0080, 16'hFF80);    // half-cell fractions
    push_req(20'hAAAAA, 16'h5555, 16'hAAAA);
    push_req(20'd100000, 16'h0001, 16'hFFFF);
    // stall burst: receiver holds off while the sender keeps going
    calm = 1'b1;
    for (int k = 0; k < 120; k++) pending_q.push_back(rand_req());
    hold_off = 150;
    drain();
    calm = 1'b0;
    write_reg(REG_UNUSED, 16'hFFFF);            // unknown register, ignored

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_GRID_WIDTH, CFG_DATA_W'(ws[ph]));
      write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(hs[ph]));
      write_reg(REG_TIME_STEP, CFG_DATA_W'(ts[ph]));
      calm = (ph == 3);
      for (int k = 0; k < 170; k++) pending_q.push_back(rand_req());
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
